// File: hw/rtl/ats_pkg.sv
// ----------------------------------------------------------------------------
// Attitude torque servo controller package
// Shared widths, register codes, fixed-point constants and the servo
// polynomial coefficient table.
// ----------------------------------------------------------------------------
package ats_pkg;

  // Fixed-point format of angles, rates, torque and the polynomial.
  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned GAIN_FRAC  = 8;

  // Field widths.
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned RATE_W     = 20;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 17;
  localparam int unsigned INTEG_W    = 18;
  localparam int unsigned SERVO_W    = 8;
  localparam int unsigned DRIVE_W    = 13;
  localparam int unsigned ERR_W      = ANGLE_W + 1;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_ANGLE     = 3'd0,
    REG_K_ANGLE        = 3'd1,
    REG_K_RATE         = 3'd2,
    REG_K_INTEGRAL     = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_TORQUE_MAX     = 3'd5
  } cfg_reg_e;

  // Register reset values.
  localparam logic signed [ANGLE_W-1:0] GOAL_ANGLE_RST     = 16'sd1073;
  localparam logic        [GAIN_W-1:0]  K_ANGLE_RST        = 16'd2509;
  localparam logic        [GAIN_W-1:0]  K_RATE_RST         = 16'd128;
  localparam logic        [GAIN_W-1:0]  K_INTEGRAL_RST     = 16'd0;
  localparam logic        [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 17'd61440;
  localparam logic        [LIMIT_W-1:0] TORQUE_MAX_RST     = 17'd36864;

  // Integral step: |err| * dt / 1000. Products at or above 1000 * 2^19 give a
  // step that clamps the integral whatever its value, so the step saturates.
  localparam int unsigned MAG_W          = 20;
  localparam int unsigned MAG_SAT_LOG2   = 19;
  localparam int unsigned PROD_W         = ANGLE_W + TIME_W;
  localparam longint      TIME_SCALE     = 1000;
  localparam logic [PROD_W-1:0] PROD_SAT = PROD_W'(TIME_SCALE << MAG_SAT_LOG2);
  localparam int unsigned QUO_IN_W       = 29;
  localparam int unsigned DIV1000_SHIFT  = 39;
  localparam int unsigned DIV1000_MUL_W  = 30;
  localparam longint      DIV1000_MUL    =
      ((64'sd1 <<< DIV1000_SHIFT) + TIME_SCALE - 1) / TIME_SCALE;
  localparam logic [MAG_W-1:0] MAG_SAT   = MAG_W'(64'sd1 <<< MAG_SAT_LOG2);
  localparam int unsigned ISUM_W         = MAG_W + 2;

  // Torque sum and the shared gain multiplier.
  localparam int unsigned MUL_B_W = RATE_W + 1;
  localparam int unsigned MUL_P_W = GAIN_W + 1 + MUL_B_W;
  localparam int unsigned SUM_W   = MUL_P_W + 1;

  // Division of the torque by seven through a reciprocal.
  localparam longint      DIVISOR     = 7;
  localparam int unsigned DIV7_SHIFT  = 20;
  localparam int unsigned DIV7_MUL_W  = 18;
  localparam longint      DIV7_MUL    = ((64'sd1 <<< DIV7_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int unsigned DIV7_Q_W    = 15;
  localparam logic [DIV7_Q_W-1:0] DRIVE_MAX = DIV7_Q_W'(8191);

  // Polynomial argument and accumulator.
  localparam int unsigned X_W      = 14;
  localparam logic [X_W-1:0] X_MAX = X_W'(64'sd2 <<< FRAC_BITS);
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned POLY_TERMS = 8;
  localparam int unsigned STEP_W   = 3;
  localparam logic [SERVO_W-1:0] SERVO_MAX = 8'd180;

  // Coefficients rounded to the nearest Q value.
  localparam longint QONE    = 64'sd1 <<< FRAC_BITS;
  localparam longint POLY_C8 = 64'sd15264 * QONE;
  localparam longint POLY_C7 = 64'sd65224 * QONE;
  localparam longint POLY_C6 = 64'sd114400 * QONE;
  localparam longint POLY_C5 = 64'sd106550 * QONE;
  localparam longint POLY_C4 = 64'sd56864 * QONE;
  localparam longint POLY_C3 = 64'sd17472 * QONE;
  localparam longint POLY_C2 = (64'sd29237 * QONE + 64'sd5) / 64'sd10;
  localparam longint POLY_C1 = (64'sd2611007 * QONE + 64'sd5000) / 64'sd10000;
  localparam longint POLY_C0 = (64'sd561953 * QONE + 64'sd5000) / 64'sd10000;

  localparam logic signed [ACC_W-1:0] POLY_LEAD = ACC_W'(POLY_C8);

  // Per-item work passed from the front end to the back end.
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [RATE_W-1:0]       abs_rate;
    logic [TIME_W-1:0]       dt;
  } work_t;

  // Gains and limits used by the back end.
  typedef struct packed {
    logic [GAIN_W-1:0]  k_angle;
    logic [GAIN_W-1:0]  k_rate;
    logic [GAIN_W-1:0]  k_integral;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] torque_max;
  } gains_t;

  // Term added after the Horner multiply of the given step.
  function automatic logic signed [ACC_W-1:0] poly_coef(input logic [STEP_W-1:0] step);
    logic signed [ACC_W-1:0] c;
    case (step)
      3'd0:    c = ACC_W'(-POLY_C7);
      3'd1:    c = ACC_W'(POLY_C6);
      3'd2:    c = ACC_W'(-POLY_C5);
      3'd3:    c = ACC_W'(POLY_C4);
      3'd4:    c = ACC_W'(-POLY_C3);
      3'd5:    c = ACC_W'(POLY_C2);
      3'd6:    c = ACC_W'(-POLY_C1);
      default: c = ACC_W'(POLY_C0);
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/ats_if.sv
// ----------------------------------------------------------------------------
// Attitude torque servo controller channels
// Valid/ready channels for sensor words, result words and register writes.
// ----------------------------------------------------------------------------

// Sensor word channel.
interface ats_in_if import ats_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] current_angle;
  logic signed [RATE_W-1:0]  angular_rate;
  logic [TIME_W-1:0]         now_ms;

  modport source (output valid, current_angle, angular_rate, now_ms, input ready);
  modport sink   (input valid, current_angle, angular_rate, now_ms, output ready);
endinterface

// Result word channel.
interface ats_out_if import ats_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [SERVO_W-1:0]        servo_angle;
  logic [DRIVE_W-1:0]        drive_torque;
  logic signed [INTEG_W-1:0] integral_value;

  modport source (output valid, servo_angle, drive_torque, integral_value, input ready);
  modport sink   (input valid, servo_angle, drive_torque, integral_value, output ready);
endinterface

// Register write channel.
interface ats_cfg_if import ats_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// File: hw/rtl/ats_fifo.sv
// ----------------------------------------------------------------------------
// Attitude torque servo work queue
// Short FIFO of classified work words between the front and back ends.
// ----------------------------------------------------------------------------
module ats_fifo import ats_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output work_t pop_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(DEPTH))
    else $error("work queue overfilled");

  // A word is only taken from a queue that holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != '0)
    else $error("work queue popped while empty");

endmodule

// File: hw/rtl/ats_front.sv
// ----------------------------------------------------------------------------
// Attitude torque servo front end
// Accepts sensor words, forms the angle error, the rate magnitude and the
// elapsed time, and pushes them into the work queue.
// ----------------------------------------------------------------------------
module ats_front import ats_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ats_in_if.sink                    in_i,
  input  logic signed [ANGLE_W-1:0] goal_angle_i,
  input  logic                      full_i,
  output logic                      push_o,
  output work_t                     work_o
);

  logic [TIME_W-1:0] last_time_q;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Error, rate magnitude and elapsed time with 32-bit wrap.
  always_comb begin
    work_o.err      = ERR_W'(goal_angle_i) - ERR_W'(in_i.current_angle);
    work_o.abs_rate = in_i.angular_rate[RATE_W-1] ? RATE_W'(-in_i.angular_rate)
                                                  : RATE_W'(in_i.angular_rate);
    work_o.dt       = in_i.now_ms - last_time_q;
  end

  // Timestamp of the last accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
    end else if (push_o) begin
      last_time_q <= in_i.now_ms;
    end
  end

endmodule

// File: hw/rtl/ats_back.sv
// ----------------------------------------------------------------------------
// Attitude torque servo back end
// Sequencer that updates the integral, forms and scales the torque with a
// shared gain multiplier and evaluates the servo polynomial by Horner steps.
// ----------------------------------------------------------------------------
module ats_back import ats_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gains_t                     gains_i,
  input  logic                       work_valid_i,
  input  work_t                      work_i,
  output logic                       work_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [SERVO_W-1:0]         servo_angle_o,
  output logic [DRIVE_W-1:0]         drive_torque_o,
  output logic signed [INTEG_W-1:0]  integral_value_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MAG      = 4'd1;
  localparam logic [3:0] S_QUOT     = 4'd2;
  localparam logic [3:0] S_INTEG    = 4'd3;
  localparam logic [3:0] S_TQ_ANGLE = 4'd4;
  localparam logic [3:0] S_TQ_RATE  = 4'd5;
  localparam logic [3:0] S_TQ_INTEG = 4'd6;
  localparam logic [3:0] S_TORQUE   = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_POLY     = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]                state_q, state_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic [RATE_W-1:0]         abs_rate_q, abs_rate_d;
  logic [TIME_W-1:0]         dt_q, dt_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic [MAG_W-1:0]          mag_q, mag_d;
  logic signed [INTEG_W-1:0] integral_q, integral_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [LIMIT_W-1:0]        torque_q, torque_d;
  logic [DRIVE_W-1:0]        drive_q, drive_d;
  logic [X_W-1:0]            x_q, x_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic                      out_valid_q, out_valid_d;
  logic [SERVO_W-1:0]        servo_angle_q;
  logic [DRIVE_W-1:0]        drive_torque_q;
  logic signed [INTEG_W-1:0] integral_value_q;

  logic [ERR_W-2:0]                         err_mag;
  logic [QUO_IN_W+DIV1000_MUL_W-1:0]        quo_full;
  logic signed [ISUM_W-1:0]                 isum, lim_s;
  logic signed [GAIN_W:0]                   mul_a;
  logic signed [MUL_B_W-1:0]                mul_b;
  logic signed [MUL_P_W-1:0]                mul_p;
  logic [SUM_W-9:0]                         sum_sh;
  logic [LIMIT_W+DIV7_MUL_W-1:0]            div_full;
  logic [DIV7_Q_W-1:0]                      div_q;
  logic [DRIVE_W-1:0]                       drive_sat;
  logic signed [ACC_W+X_W:0]                hprod;
  logic [SERVO_W-1:0]                       angle;
  logic [ACC_W-FRAC_BITS-1:0]               acc_int;
  logic                                     load;

  assign err_mag    = err_q[ERR_W-1] ? (ERR_W-1)'(-err_q) : (ERR_W-1)'(err_q);
  assign quo_full   = prod_q[QUO_IN_W-1:0] * DIV1000_MUL_W'(DIV1000_MUL);
  assign lim_s      = $signed(ISUM_W'(gains_i.integral_limit));
  assign isum       = err_q[ERR_W-1] ? ISUM_W'(integral_q) - $signed(ISUM_W'(mag_q))
                                     : ISUM_W'(integral_q) + $signed(ISUM_W'(mag_q));
  assign mul_p      = mul_a * mul_b;
  assign sum_sh     = sum_q[SUM_W-1:GAIN_FRAC];
  assign div_full   = torque_q * DIV7_MUL_W'(DIV7_MUL);
  assign div_q      = div_full[DIV7_SHIFT +: DIV7_Q_W];
  assign drive_sat  = (div_q > DRIVE_MAX) ? DRIVE_W'(DRIVE_MAX) : div_q[DRIVE_W-1:0];
  assign hprod      = acc_q * $signed({1'b0, x_q});
  assign acc_int    = acc_q[ACC_W-1:FRAC_BITS];
  assign load       = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign work_pop_o = (state_q == S_IDLE) && work_valid_i;

  // Shared gain multiplier operands for the three torque terms.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_TQ_ANGLE: begin
        mul_a = $signed({1'b0, gains_i.k_angle});
        mul_b = MUL_B_W'(err_q);
      end
      S_TQ_RATE: begin
        mul_a = $signed({1'b0, gains_i.k_rate});
        mul_b = -$signed({1'b0, abs_rate_q});
      end
      S_TQ_INTEG: begin
        mul_a = $signed({1'b0, gains_i.k_integral});
        mul_b = MUL_B_W'(integral_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Servo angle in whole degrees, floored and saturated.
  always_comb begin
    if (acc_q <= 0) begin
      angle = '0;
    end else if (acc_int > (ACC_W-FRAC_BITS)'(SERVO_MAX)) begin
      angle = SERVO_MAX;
    end else begin
      angle = acc_int[SERVO_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    abs_rate_d  = abs_rate_q;
    dt_d        = dt_q;
    prod_d      = prod_q;
    mag_d       = mag_q;
    integral_d  = integral_q;
    sum_d       = sum_q;
    torque_d    = torque_q;
    drive_d     = drive_q;
    x_d         = x_q;
    acc_d       = acc_q;
    step_d      = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (work_valid_i) begin
          err_d      = work_i.err;
          abs_rate_d = work_i.abs_rate;
          dt_d       = work_i.dt;
          state_d    = S_MAG;
        end
      end
      S_MAG: begin
        prod_d  = err_mag * dt_q;
        state_d = S_QUOT;
      end
      S_QUOT: begin
        mag_d   = (prod_q >= PROD_SAT) ? MAG_SAT : quo_full[DIV1000_SHIFT +: MAG_W];
        state_d = S_INTEG;
      end
      S_INTEG: begin
        if (isum > lim_s) begin
          integral_d = INTEG_W'(lim_s);
        end else if (isum < -lim_s) begin
          integral_d = INTEG_W'(-lim_s);
        end else begin
          integral_d = INTEG_W'(isum);
        end
        state_d = S_TQ_ANGLE;
      end
      S_TQ_ANGLE: begin
        sum_d   = SUM_W'(mul_p);
        state_d = S_TQ_RATE;
      end
      S_TQ_RATE: begin
        sum_d   = sum_q + SUM_W'(mul_p);
        state_d = S_TQ_INTEG;
      end
      S_TQ_INTEG: begin
        sum_d   = sum_q + SUM_W'(mul_p);
        state_d = S_TORQUE;
      end
      S_TORQUE: begin
        if (sum_q <= 0) begin
          torque_d = '0;
        end else if (sum_sh > (SUM_W-8)'(gains_i.torque_max)) begin
          torque_d = gains_i.torque_max;
        end else begin
          torque_d = sum_sh[LIMIT_W-1:0];
        end
        state_d = S_DIV;
      end
      S_DIV: begin
        drive_d = drive_sat;
        x_d     = (X_W'(drive_sat) > X_MAX) ? X_MAX : X_W'(drive_sat);
        acc_d   = POLY_LEAD;
        step_d  = '0;
        state_d = S_POLY;
      end
      S_POLY: begin
        acc_d  = $signed(hprod[FRAC_BITS +: ACC_W]) + poly_coef(step_q);
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(POLY_TERMS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      integral_q  <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      integral_q  <= integral_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    abs_rate_q <= abs_rate_d;
    dt_q       <= dt_d;
    prod_q     <= prod_d;
    mag_q      <= mag_d;
    sum_q      <= sum_d;
    torque_q   <= torque_d;
    drive_q    <= drive_d;
    x_q        <= x_d;
    acc_q      <= acc_d;
    if (load) begin
      servo_angle_q    <= angle;
      drive_torque_q   <= drive_q;
      integral_value_q <= integral_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign servo_angle_o    = servo_angle_q;
  assign drive_torque_o   = drive_torque_q;
  assign integral_value_o = integral_value_q;

  // The integral just updated lies within the clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == S_TQ_ANGLE |->
        (ISUM_W'(integral_q) <= lim_s) && (ISUM_W'(integral_q) >= -lim_s))
    else $error("integral outside its limit");

  // The clamped torque never exceeds the torque limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == S_DIV |-> torque_q <= gains_i.torque_max)
    else $error("torque above its limit");

  // A result word only appears as the sequencer finishes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result word raised outside the final step");

endmodule

// File: hw/rtl/attitude_torque_servo_controller_core.sv
// ----------------------------------------------------------------------------
// Attitude torque servo controller core
// Register file, sensor front end, work queue and arithmetic back end.
// ----------------------------------------------------------------------------
// Sequence: an accepted sensor word passes the work queue; the back end then
//   updates the integral, forms and scales the torque and evaluates the polynomial.
// Sequencing: the back-end sequencer takes no new word until the last result is
//   loaded; it has its shared gain multiplier and eight Horner steps on one multiplier.
// Reset: clears the integral, the last timestamp, the queue and the output
//   valid, and loads the register reset values; no clearing pass is needed.
module attitude_torque_servo_controller_core import ats_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ats_in_if.sink    in_i,
  ats_out_if.source out_o,
  ats_cfg_if.sink   cfg_i
);

  logic signed [ANGLE_W-1:0] goal_angle_q;
  gains_t                    gains_q;
  logic                      push;
  logic                      full;
  work_t                     push_word;
  logic                      pop;
  logic                      queue_valid;
  work_t                     pop_word;

  // Register writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_angle_q           <= GOAL_ANGLE_RST;
      gains_q.k_angle        <= K_ANGLE_RST;
      gains_q.k_rate         <= K_RATE_RST;
      gains_q.k_integral     <= K_INTEGRAL_RST;
      gains_q.integral_limit <= INTEGRAL_LIMIT_RST;
      gains_q.torque_max     <= TORQUE_MAX_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_GOAL_ANGLE:     goal_angle_q           <= $signed(cfg_i.wdata[ANGLE_W-1:0]);
        REG_K_ANGLE:        gains_q.k_angle        <= cfg_i.wdata[GAIN_W-1:0];
        REG_K_RATE:         gains_q.k_rate         <= cfg_i.wdata[GAIN_W-1:0];
        REG_K_INTEGRAL:     gains_q.k_integral     <= cfg_i.wdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: gains_q.integral_limit <= cfg_i.wdata[LIMIT_W-1:0];
        REG_TORQUE_MAX:     gains_q.torque_max     <= cfg_i.wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: takes sensor words and classifies them into work words.
  ats_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .goal_angle_i (goal_angle_q),
    .full_i       (full),
    .push_o       (push),
    .work_o       (push_word)
  );

  // Work queue decoupling the two ends.
  ats_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_word),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .pop_data_o  (pop_word)
  );

  // Back end: integral, torque, scaling and servo polynomial.
  ats_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .gains_i          (gains_q),
    .work_valid_i     (queue_valid),
    .work_i           (pop_word),
    .work_pop_o       (pop),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .servo_angle_o    (out_o.servo_angle),
    .drive_torque_o   (out_o.drive_torque),
    .integral_value_o (out_o.integral_value)
  );

endmodule
